// ----- hdl/assert_macros.svh -----
// assertion macros used by lfu_cache_replacement
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hdl/lfu_pkg.sv -----
// shared types and fixed field widths of the lfu block table
// no dependencies
`default_nettype none

package lfu_pkg;

    localparam int SIZE_BITS       = 16;
    localparam int STAMP_BITS      = 32;
    localparam int BYTES_BITS      = 32;
    localparam int PORT_KEY_BITS   = 32;
    localparam int PORT_COUNT_BITS = 16;
    localparam int PORT_SLOT_BITS  = 4;
    localparam logic [BYTES_BITS-1:0] CAPACITY_RESET = 32'd65536;

    typedef enum logic {
        FUNC_ACCESS = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef struct packed {
        logic key_match;
        logic better;
    } t_cmp_flags;

endpackage

`default_nettype wire

// ----- hdl/lfu_cmp.sv -----
// compare unit: key match and victim ranking of one table entry per cycle
// depends on lfu_pkg
`default_nettype none

module lfu_cmp import lfu_pkg::*; #(
    parameter int KS = 32,
    parameter int CB = 16
) (
    input  wire logic                  i_entry_valid,
    input  wire logic [KS-1:0]         i_entry_key,
    input  wire logic [CB-1:0]         i_entry_count,
    input  wire logic [STAMP_BITS-1:0] i_entry_stamp,
    input  wire logic [KS-1:0]         i_key,
    input  wire logic [STAMP_BITS-1:0] i_clock,
    input  wire logic                  i_best_found,
    input  wire logic [CB-1:0]         i_best_count,
    input  wire logic [STAMP_BITS-1:0] i_best_age,
    output logic      [STAMP_BITS-1:0] o_age,
    output t_cmp_flags                 o_flags
);

    assign o_age = i_clock - i_entry_stamp;

    always_comb begin
        o_flags.key_match = i_entry_valid && (i_entry_key == i_key);
        o_flags.better    = i_entry_valid &&
                            (!i_best_found ||
                             (i_entry_count < i_best_count) ||
                             ((i_entry_count == i_best_count) && (o_age > i_best_age)));
    end

endmodule

`default_nettype wire

// ----- hdl/lfu_cache_replacement.sv -----
// lfu block table with lru tiebreak and byte accounting, top level
// depends on lfu_pkg, lfu_cmp and assert_macros.svh
//
//   channel   signals                                   direction
//   in        i_in_valid / o_in_stall, func key size    into block
//   out       o_out_valid / i_out_stall, result fields  out of block
//   cfg       i_cfg_wr_en / i_cfg_wr_data               into block
//
// an item goes from transfer to result through the scan, check and commit states:
// in scan one entry of the table memory is read and ranked per cycle by the compare unit,
// then check does the budget check and commit does the table update, waiting on the output
// o_in_stall is high from the input transfer until the result is loaded
// a result waits in the output register while i_out_stall is high
// synchronous active-low reset clears valid bits, byte count and access clock
`default_nettype none
`include "assert_macros.svh"

module lfu_cache_replacement import lfu_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [BYTES_BITS-1:0]      i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_func,
    input  wire logic [PORT_KEY_BITS-1:0]   i_block_key,
    input  wire logic [SIZE_BITS-1:0]       i_block_size,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_hit,
    output logic [PORT_SLOT_BITS-1:0]       o_slot,
    output logic [PORT_COUNT_BITS-1:0]      o_use_count,
    output logic                            o_evicted,
    output logic [PORT_KEY_BITS-1:0]        o_evicted_key,
    output logic [SIZE_BITS-1:0]            o_evicted_size
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KS = (KEY_BITS < PORT_KEY_BITS) ? KEY_BITS : PORT_KEY_BITS;
    localparam int CB = COUNT_BITS;
    localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_COMMIT
    } t_state;

    t_state r_state;

    logic [KS-1:0]         mem_key   [ENTRIES];
    logic [SIZE_BITS-1:0]  mem_size  [ENTRIES];
    logic [CB-1:0]         mem_count [ENTRIES];
    logic [STAMP_BITS-1:0] mem_stamp [ENTRIES];

    logic [ENTRIES-1:0]    r_valid;
    logic [BYTES_BITS-1:0] r_cap;
    logic [BYTES_BITS-1:0] r_bytes;
    logic [STAMP_BITS-1:0] r_clock;

    t_func                 r_func;
    logic [KS-1:0]         r_key;
    logic [SIZE_BITS-1:0]  r_size;

    logic                  r_issue;
    logic [SW-1:0]         r_addr;
    logic                  r_ev_vld;
    logic [SW-1:0]         r_ev_idx;

    logic [KS-1:0]         r_rd_key;
    logic [SIZE_BITS-1:0]  r_rd_size;
    logic [CB-1:0]         r_rd_count;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    logic                  r_found;
    logic [SW-1:0]         r_fnd_idx;
    logic [SIZE_BITS-1:0]  r_fnd_size;
    logic [CB-1:0]         r_fnd_count;

    logic                  r_vic_found;
    logic [SW-1:0]         r_vic_idx;
    logic [KS-1:0]         r_vic_key;
    logic [SIZE_BITS-1:0]  r_vic_size;
    logic [CB-1:0]         r_vic_count;
    logic [STAMP_BITS-1:0] r_vic_age;

    logic                  r_free_found;
    logic [SW-1:0]         r_free_idx;

    logic                  r_over;
    logic [BYTES_BITS-1:0] r_bytes_less;

    logic                       r_o_valid;
    logic                       r_o_hit;
    logic [PORT_SLOT_BITS-1:0]  r_o_slot;
    logic [PORT_COUNT_BITS-1:0] r_o_count;
    logic                       r_o_evicted;
    logic [PORT_KEY_BITS-1:0]   r_o_ev_key;
    logic [SIZE_BITS-1:0]       r_o_ev_size;

    logic [STAMP_BITS-1:0] cmp_age;
    t_cmp_flags            cmp_flags;
    logic                  in_xfer;
    logic                  load_ok;
    logic                  mem_re;
    logic                  mem_we;
    logic [SW-1:0]         w_idx;
    logic [CB-1:0]         w_count;
    logic [SIZE_BITS-1:0]  w_size;
    logic                  is_access_hit;
    logic                  is_remove_hit;
    logic                  do_evict;
    logic                  do_insert;
    logic [SW-1:0]         ins_idx;
    logic [CB-1:0]         n_count;
    logic [BYTES_BITS-1:0] n_bytes_ins;

    lfu_cmp #(
        .KS (KS),
        .CB (CB)
    ) u_cmp (
        .i_entry_valid (r_valid[r_ev_idx]),
        .i_entry_key   (r_rd_key),
        .i_entry_count (r_rd_count),
        .i_entry_stamp (r_rd_stamp),
        .i_key         (r_key),
        .i_clock       (r_clock),
        .i_best_found  (r_vic_found),
        .i_best_count  (r_vic_count),
        .i_best_age    (r_vic_age),
        .o_age         (cmp_age),
        .o_flags       (cmp_flags)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign load_ok    = !r_o_valid || !i_out_stall;
    assign mem_re     = (r_state == S_SCAN) && r_issue;

    always_comb begin
        is_access_hit = (r_func == FUNC_ACCESS) && r_found;
        is_remove_hit = (r_func == FUNC_REMOVE) && r_found;
        do_evict      = (r_func == FUNC_ACCESS) && !r_found &&
                        (r_over || !r_free_found) && r_vic_found;
        do_insert     = (r_func == FUNC_ACCESS) && !r_found && (do_evict || r_free_found);
        if (do_evict) begin
            ins_idx = (r_free_found && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;
        end else begin
            ins_idx = r_free_idx;
        end
        n_count     = (r_fnd_count == {CB{1'b1}}) ? r_fnd_count : r_fnd_count + CB'(1);
        n_bytes_ins = (do_evict ? r_bytes_less : r_bytes) + BYTES_BITS'(r_size);
        mem_we      = (r_state == S_COMMIT) && load_ok && (is_access_hit || do_insert);
        w_idx       = is_access_hit ? r_fnd_idx : ins_idx;
        w_count     = is_access_hit ? n_count : CB'(1);
        w_size      = is_access_hit ? r_fnd_size : r_size;
    end

    // table memory, one registered read port and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[w_idx]   <= r_key;
            mem_size[w_idx]  <= w_size;
            mem_count[w_idx] <= w_count;
            mem_stamp[w_idx] <= r_clock;
        end
        if (mem_re) begin
            r_rd_key   <= mem_key[r_addr];
            r_rd_size  <= mem_size[r_addr];
            r_rd_count <= mem_count[r_addr];
            r_rd_stamp <= mem_stamp[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cap     <= CAPACITY_RESET;
            r_bytes   <= '0;
            r_clock   <= '0;
            r_issue   <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_func       <= t_func'(i_func);
                        r_key        <= KS'(i_block_key);
                        r_size       <= i_block_size;
                        r_addr       <= '0;
                        r_issue      <= 1'b1;
                        r_ev_vld     <= 1'b0;
                        r_found      <= 1'b0;
                        r_vic_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // issue side
                    r_ev_vld <= r_issue;
                    r_ev_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + SW'(1);
                        end
                    end
                    // ranking side
                    if (r_ev_vld) begin
                        if (cmp_flags.key_match && !r_found) begin
                            r_found     <= 1'b1;
                            r_fnd_idx   <= r_ev_idx;
                            r_fnd_size  <= r_rd_size;
                            r_fnd_count <= r_rd_count;
                        end
                        if (cmp_flags.better) begin
                            r_vic_found <= 1'b1;
                            r_vic_idx   <= r_ev_idx;
                            r_vic_key   <= r_rd_key;
                            r_vic_size  <= r_rd_size;
                            r_vic_count <= r_rd_count;
                            r_vic_age   <= cmp_age;
                        end
                        if (!r_valid[r_ev_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_ev_idx;
                        end
                        if (r_ev_idx == LAST) begin
                            r_ev_vld <= 1'b0;
                            r_state  <= S_CHECK;
                        end
                    end
                end

                S_CHECK: begin
                    r_over       <= ({1'b0, r_bytes} + (BYTES_BITS+1)'(r_size)) >
                                    {1'b0, r_cap};
                    r_bytes_less <= r_bytes - BYTES_BITS'(r_vic_size);
                    r_state      <= S_COMMIT;
                end

                S_COMMIT: begin
                    if (load_ok) begin
                        r_o_valid   <= 1'b1;
                        r_o_hit     <= r_found;
                        r_o_evicted <= do_evict;
                        r_o_ev_key  <= do_evict ? PORT_KEY_BITS'(r_vic_key) : '0;
                        r_o_ev_size <= do_evict ? r_vic_size : '0;
                        if (r_found) begin
                            r_o_slot <= PORT_SLOT_BITS'(r_fnd_idx);
                        end else if (do_insert) begin
                            r_o_slot <= PORT_SLOT_BITS'(ins_idx);
                        end else begin
                            r_o_slot <= '0;
                        end
                        if (is_remove_hit) begin
                            r_o_count <= PORT_COUNT_BITS'(r_fnd_count);
                        end else if (is_access_hit) begin
                            r_o_count <= PORT_COUNT_BITS'(n_count);
                        end else if (do_insert) begin
                            r_o_count <= PORT_COUNT_BITS'(1);
                        end else begin
                            r_o_count <= '0;
                        end

                        if (is_remove_hit) begin
                            r_valid[r_fnd_idx] <= 1'b0;
                            r_bytes            <= r_bytes - BYTES_BITS'(r_fnd_size);
                        end
                        if (is_access_hit) begin
                            r_clock <= r_clock + STAMP_BITS'(1);
                        end
                        if (do_evict) begin
                            r_valid[r_vic_idx] <= 1'b0;
                        end
                        if (do_insert) begin
                            r_valid[ins_idx] <= 1'b1;
                            r_bytes          <= n_bytes_ins;
                            r_clock          <= r_clock + STAMP_BITS'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_slot         = r_o_slot;
    assign o_use_count    = r_o_count;
    assign o_evicted      = r_o_evicted;
    assign o_evicted_key  = r_o_ev_key;
    assign o_evicted_size = r_o_ev_size;

    `ASSERT_RST(a_xfer_starts_scan, i_clk, i_rst_n, in_xfer |=> (r_state == S_SCAN))
    `ASSERT_RST(a_hit_never_evicts, i_clk, i_rst_n, (o_out_valid && o_hit) |-> !o_evicted)
    `ASSERT_RST(a_no_evict_zero_fields, i_clk, i_rst_n,
        (o_out_valid && !o_evicted) |-> ((o_evicted_key == '0) && (o_evicted_size == '0)))
    `ASSERT_RST(a_clock_moves_in_commit, i_clk, i_rst_n,
        (r_state != S_COMMIT) |=> $stable(r_clock))

endmodule

`default_nettype wire
